@@ rtl/brf_pkg.sv @@
`default_nettype none

package brf_pkg;

  localparam int STEP_W   = 2;
  localparam int BUF_AW   = 3;
  localparam int CNT_W    = BUF_AW + 1;
  localparam int DIGIT_W  = 4;
  localparam int CHAR_W   = 7;
  localparam int MAG_W    = 8;
  localparam int OP_W     = 3;

  localparam logic [CNT_W-1:0] BUF_DEPTH = CNT_W'(1 << BUF_AW);

  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 7'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_ALPHA = 7'h37;

  localparam logic [3:0] DEC_RADIX = 4'd10;

  typedef enum logic [OP_W-1:0] {
    OP_OCT  = 3'd0,
    OP_HEX  = 3'd1,
    OP_UDEC = 3'd2,
    OP_SDEC = 3'd3,
    OP_SMAG = 3'd4,
    OP_BIN  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    RADIX_BIN = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_DEC = 2'd2,
    RADIX_HEX = 2'd3
  } radix_t;

  typedef enum logic [1:0] {
    COND_NEVER    = 2'd0,
    COND_BAD_OP   = 2'd1,
    COND_DIV_MORE = 2'd2,
    COND_CHARS    = 2'd3
  } cond_t;

  typedef struct packed {
    logic              accept;
    logic              divide;
    logic              emit_sign;
    logic              emit_digit;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctrl_word_t;

  typedef enum logic [STEP_W-1:0] {
    STEP_WAIT = 2'd0,
    STEP_DIV  = 2'd1,
    STEP_SIGN = 2'd2,
    STEP_EMIT = 2'd3
  } step_t;

  // program: the step after the last wraps back to the wait step
  function automatic ctrl_word_t ucode_rom(input logic [STEP_W-1:0] step);
    ctrl_word_t cw;
    cw = '{accept: 1'b0, divide: 1'b0, emit_sign: 1'b0, emit_digit: 1'b0,
           cond: COND_NEVER, target: STEP_WAIT};
    unique case (step)
      STEP_WAIT: begin
        cw.accept = 1'b1;
        cw.cond   = COND_BAD_OP;
        cw.target = STEP_WAIT;
      end
      STEP_DIV: begin
        cw.divide = 1'b1;
        cw.cond   = COND_DIV_MORE;
        cw.target = STEP_DIV;
      end
      STEP_SIGN: begin
        cw.emit_sign = 1'b1;
      end
      STEP_EMIT: begin
        cw.emit_digit = 1'b1;
        cw.cond       = COND_CHARS;
        cw.target     = STEP_EMIT;
      end
      default: ;
    endcase
    return cw;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_W'(DEC_RADIX)) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_ALPHA + CHAR_W'(d);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/brf_digit_unit.sv @@
`default_nettype none

module brf_digit_unit (
  input  wire logic [7:0]      mag,
  input  wire brf_pkg::radix_t radix,
  output logic [7:0]           quot,
  output logic [3:0]           rem
);
  import brf_pkg::*;

  logic [15:0] prod;
  logic [4:0]  q10;
  logic [7:0]  r10;

  // divide by ten through the reciprocal 205/2048, exact over a byte
  assign prod = {8'd0, mag} * 16'd205;
  assign q10  = prod[15:11];
  assign r10  = mag - {q10, 3'b000} - {2'b00, q10, 1'b0};

  always_comb begin
    unique case (radix)
      RADIX_BIN: begin
        quot = {1'b0, mag[7:1]};
        rem  = {3'b000, mag[0]};
      end
      RADIX_OCT: begin
        quot = {3'b000, mag[7:3]};
        rem  = {1'b0, mag[2:0]};
      end
      RADIX_DEC: begin
        quot = {3'b000, q10};
        rem  = r10[3:0];
      end
      RADIX_HEX: begin
        quot = {4'b0000, mag[7:4]};
        rem  = mag[3:0];
      end
      default: begin
        quot = 8'd0;
        rem  = 4'd0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/byte_to_radix_ascii_formatter.sv @@
// Byte to ASCII text formatter.
// Slave channel: one request per byte; s_tdata holds the value, s_tuser the
// format (octal, hex, unsigned decimal, two's complement decimal,
// sign-magnitude decimal, binary). Formats 6 and 7 are taken and dropped.
// Master channel: one ASCII character per beat in m_tdata, most significant
// digit first, m_tlast on the final character of each request.
// A small microcode program (wait, divide, sign, emit) runs the datapath.
// The divide step takes one digit per cycle from a shared digit unit and
// stores it; the emit step then sends one character per cycle from the
// digit store while the receiver takes each one. A request holds d digits
// (d is 1 to 8) and passes the wait, divide, sign and emit steps in order;
// the sign step is passed whether or not a sign is written.
// The output register holds the last character while the next request is
// accepted. A stalled receiver holds m_tdata and m_tlast and, in the sign
// and emit steps, freezes the program until the character is taken. Reset
// empties the output register and returns the program to the wait step.
`default_nettype none

module byte_to_radix_ascii_formatter (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] value
  input  wire logic [2:0] s_tuser,   // [2:0] op
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [6:0] text_char, [7] zero
  output logic            m_tlast
);
  import brf_pkg::*;

  logic [STEP_W-1:0]  step;
  logic [STEP_W-1:0]  step_next;
  ctrl_word_t         cw;

  logic [MAG_W-1:0]   mag;
  radix_t             radix;
  logic               sign_pend;
  logic [CHAR_W-1:0]  sign_char;
  logic               pad8;
  logic [CNT_W-1:0]   cnt;
  logic [DIGIT_W-1:0] digit_buf [1 << BUF_AW];

  logic [CHAR_W-1:0]  out_char;
  logic               out_last;

  logic [MAG_W-1:0]   quot;
  logic [DIGIT_W-1:0] rem;
  logic [CNT_W-1:0]   cnt_inc;
  logic [CNT_W-1:0]   cnt_dec;
  logic               slot_free;
  logic               done;
  logic               cond_hit;
  logic               load_sign;
  logic               load_digit;
  logic               op_bad;
  logic [MAG_W-1:0]   mag_load;
  radix_t             radix_load;

  assign cw        = ucode_rom(step);
  assign s_tready  = cw.accept;
  assign slot_free = !m_tvalid || m_tready;
  assign cnt_inc   = cnt + CNT_W'(1);
  assign cnt_dec   = cnt - CNT_W'(1);
  assign op_bad    = s_tuser > OP_BIN;

  assign load_sign  = cw.emit_sign && sign_pend && slot_free;
  assign load_digit = cw.emit_digit && slot_free;

  brf_digit_unit u_digit (
    .mag   (mag),
    .radix (radix),
    .quot  (quot),
    .rem   (rem)
  );

  always_comb begin
    unique case (s_tuser)
      OP_OCT:  radix_load = RADIX_OCT;
      OP_HEX:  radix_load = RADIX_HEX;
      OP_BIN:  radix_load = RADIX_BIN;
      default: radix_load = RADIX_DEC;
    endcase
    priority if (s_tuser == OP_SDEC && s_tdata[7]) begin
      mag_load = ~s_tdata + 8'd1;
    end else if (s_tuser == OP_SMAG) begin
      mag_load = {1'b0, s_tdata[6:0]};
    end else begin
      mag_load = s_tdata;
    end
  end

  always_comb begin
    priority if (cw.accept) begin
      done = s_tvalid;
    end else if (cw.emit_sign) begin
      done = !sign_pend || slot_free;
    end else if (cw.emit_digit) begin
      done = slot_free;
    end else begin
      done = 1'b1;
    end
    unique case (cw.cond)
      COND_NEVER:    cond_hit = 1'b0;
      COND_BAD_OP:   cond_hit = op_bad;
      COND_DIV_MORE: cond_hit = (quot != '0 || pad8) && cnt_inc < BUF_DEPTH;
      COND_CHARS:    cond_hit = cnt != CNT_W'(1);
      default:       cond_hit = 1'b0;
    endcase
    step_next = step;
    if (done) begin
      step_next = cond_hit ? cw.target : step + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= STEP_WAIT;
      m_tvalid <= 1'b0;
    end else begin
      step <= step_next;
      if (load_sign || load_digit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cw.accept && s_tvalid) begin
      mag       <= mag_load;
      radix     <= radix_load;
      sign_pend <= s_tuser == OP_SMAG || (s_tuser == OP_SDEC && s_tdata[7]);
      sign_char <= s_tdata[7] ? CHAR_MINUS : CHAR_PLUS;
      pad8      <= s_tuser == OP_BIN && s_tdata != 8'd0;
      cnt       <= '0;
    end
    if (cw.divide) begin
      digit_buf[cnt[BUF_AW-1:0]] <= rem;
      mag                        <= quot;
      cnt                        <= cnt_inc;
    end
    if (load_sign) begin
      out_char <= sign_char;
      out_last <= 1'b0;
    end
    if (load_digit) begin
      out_char <= digit_char(digit_buf[cnt_dec[BUF_AW-1:0]]);
      out_last <= cnt == CNT_W'(1);
      cnt      <= cnt_dec;
    end
  end

  assign m_tdata = {1'b0, out_char};
  assign m_tlast = out_last;

endmodule

`default_nettype wire

@@ bench/tb_byte_to_radix_ascii_formatter.sv @@
`default_nettype none

module tb_byte_to_radix_ascii_formatter;
  import brf_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
  localparam int STALL_LIMIT    = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_PER_PHASE = 47;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  class ascii_text_tracker;
    text_char_t pending_chars[$];
    int         failures = 0;

    function void format_byte(input logic [OP_W-1:0] op, input logic [7:0] value);
      string             glyphs;
      logic [CHAR_W-1:0] text[$];
      logic [7:0]        mag;
      int                radix;
      int                min_len;
      logic              has_sign;
      logic [CHAR_W-1:0] sign_ch;
      text_char_t        e;
      glyphs   = "0123456789ABCDEF";
      mag      = value;
      min_len  = 1;
      has_sign = 1'b0;
      sign_ch  = CHAR_PLUS;
      case (op)
        OP_OCT:  radix = 8;
        OP_HEX:  radix = 16;
        OP_UDEC: radix = 10;
        OP_SDEC: begin
          radix = 10;
          if (value[7]) begin
            has_sign = 1'b1;
            sign_ch  = CHAR_MINUS;
            mag      = 8'd0 - value;
          end
        end
        OP_SMAG: begin
          radix    = 10;
          has_sign = 1'b1;
          sign_ch  = value[7] ? CHAR_MINUS : CHAR_PLUS;
          mag      = {1'b0, value[6:0]};
        end
        OP_BIN: begin
          radix   = 2;
          min_len = (value == 8'd0) ? 1 : 8;
        end
        default: return;
      endcase
      do begin
        text.push_front(CHAR_W'(glyphs[mag % radix]));
        mag = mag / radix;
      end while (mag != 8'd0);
      while (text.size() < min_len) text.push_front(CHAR_ZERO);
      if (has_sign) text.push_front(sign_ch);
      foreach (text[k]) begin
        e.ch   = text[k];
        e.last = (k == text.size() - 1);
        pending_chars.push_back(e);
      end
    endfunction

    function void match_char(input logic [7:0] data, input logic last);
      text_char_t e;
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected character data=%h last=%b", $time, data, last);
        failures++;
        return;
      end
      e = pending_chars.pop_front();
      if (data !== {1'b0, e.ch}) begin
        $display("%0t: tdata mismatch expected=%h actual=%h", $time, {1'b0, e.ch}, data);
        failures++;
      end
      if (last !== e.last) begin
        $display("%0t: tlast mismatch expected=%b actual=%b", $time, e.last, last);
        failures++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;
  logic [2:0] s_tuser = '0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;

  ascii_text_tracker tracker;
  int src_idle   = 0;
  int sink_stall = 0;
  int quiet_cycles = 0;

  byte_to_radix_ascii_formatter i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) tracker.format_byte(s_tuser, s_tdata);
      if (m_tvalid && m_tready) tracker.match_char(m_tdata, m_tlast);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [OP_W-1:0] op, input logic [7:0] value);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_random_run(input int count);
    int         sent;
    logic [2:0] op;
    logic [7:0] value;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) == 0) begin
        op = $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
      end else begin
        op = OP_W'($urandom_range(OP_BIN, OP_OCT));
        sent++;
      end
      case ($urandom_range(7))
        0: value = 8'h00;
        1: value = 8'h80;
        2: value = 8'hFF;
        3: value = 8'h7F;
        default: value = 8'($urandom_range(255));
      endcase
      send_request(op, value);
    end
  endtask

  initial begin
    op_t op;
    tracker = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every format at zero, most negative and all ones
    for (int i = OP_OCT; i <= OP_BIN; i++) begin
      op = op_t'(i);
      send_request(op, 8'h00);
      send_request(op, 8'h80);
      send_request(op, 8'hFF);
    end
    send_request(OP_SMAG, 8'h7F);
    send_request(OP_SDEC, 8'h7F);
    send_request(OP_BIN, 8'h01);
    send_request(OP_HEX, 8'hA5);
    send_request(OP_SPARE_LO, 8'hAA);
    send_request(OP_SPARE_HI, 8'h55);

    send_random_run(RANDOM_PER_PHASE);
    src_idle = 85;
    send_random_run(RANDOM_PER_PHASE);
    src_idle   = 0;
    sink_stall = 85;
    send_random_run(RANDOM_PER_PHASE);
    src_idle   = 24;
    sink_stall = 24;
    send_random_run(RANDOM_PER_PHASE);
    s_tvalid <= 1'b0;
    @(posedge clk);

    while (tracker.pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending_chars.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/brf_pkg.sv
rtl/brf_digit_unit.sv
rtl/byte_to_radix_ascii_formatter.sv
bench/tb_byte_to_radix_ascii_formatter.sv
